FILE: rtl/core/sshdfr_pkg.sv
// shared types and constants for the ssh binary packet deframer
// used by sshdfr_front, sshdfr_queue, sshdfr_back and the top level
`timescale 1ns / 1ps

package sshdfr_pkg;

   // result classification
   typedef enum logic [2:0] {
      KIND_NONE       = 3'd0,
      KIND_BANNER_CHR = 3'd1,
      KIND_BANNER_END = 3'd2,
      KIND_PAYLOAD    = 3'd3,
      KIND_BAD_LENGTH = 3'd4,
      KIND_BAD_PADDING= 3'd5
   } kind_type;

   // one classified word handed from the front to the back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        payload_last;
      logic        packet_end;
      logic [7:0]  packet_type;
      logic [11:0] payload_length;
   } event_type;

   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_CR = 8'h0d;

   // smallest legal packet length
   localparam logic [31:0] LENGTH_MIN = 32'd6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

endpackage

FILE: rtl/core/ssh_binary_packet_deframer.sv
// ssh binary packet deframer, top level: front parser, word queue, back end
// depends on sshdfr_pkg, sshdfr_front, sshdfr_queue, sshdfr_back
`timescale 1ns / 1ps

// Takes one received word per clock while req_stall is low, and returns
// exactly one result word for each. After reset or a new-connection word it
// passes the identification line (CR dropped, up to BANNER_CAP-1 characters
// kept, LF ends it), then deframes binary packets: payload bytes stream out
// as they arrive, the last one flagged, and the packet's last byte reports
// type and payload length. Bad lengths and bad padding are counted in
// error_total. A word is parsed in the cycle it is accepted, is written into
// the queue, and moves into the result register when the back end pops it; a
// two-word queue and the result register let the input keep taking one word
// every cycle while the rsp side is not stalled, and req_stall rises only
// once that queue has filled behind a stalled output.

module ssh_binary_packet_deframer #(
   parameter int PACKET_MAX = 4096,
   parameter int BANNER_CAP = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_payload_last,
   output logic        rsp_packet_end,
   output logic [7:0]  rsp_packet_type,
   output logic [11:0] rsp_payload_length,
   output logic [31:0] rsp_error_total,
   output logic [31:0] rsp_packet_total
);

   logic                  q_full;
   logic                  q_not_empty;
   logic                  q_pop;
   logic                  take;
   sshdfr_pkg::event_type front_event;
   sshdfr_pkg::event_type q_event;

   assign take      = req_valid && !q_full;
   assign req_stall = q_full;

   sshdfr_front #(
      .PACKET_MAX(PACKET_MAX),
      .BANNER_CAP(BANNER_CAP)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .operation (req_operation),
      .data_byte (req_data_byte),
      .result    (front_event)
   );

   sshdfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_event (front_event),
      .full       (q_full),
      .pop        (q_pop),
      .pop_event  (q_event),
      .not_empty  (q_not_empty)
   );

   sshdfr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_event            (q_event),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_out       (rsp_data_out),
      .rsp_payload_last   (rsp_payload_last),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_error_total    (rsp_error_total),
      .rsp_packet_total   (rsp_packet_total)
   );

   // a well-formed packet always carries at least its type byte
   a_end_has_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_payload_length != 12'd0)
      else $error("packet end with empty payload");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_last |-> rsp_kind == sshdfr_pkg::KIND_PAYLOAD)
      else $error("payload_last on a non-payload word");

   a_error_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == sshdfr_pkg::KIND_BAD_LENGTH ||
                    rsp_kind == sshdfr_pkg::KIND_BAD_PADDING)
      |-> !rsp_packet_end && !rsp_payload_last)
      else $error("framing error word also marks a packet");

   // the front never hands a word to a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |=> !(q_full && $past(take) && !$past(q_pop)) || $past(!q_full))
      else $error("word queue overflow");

endmodule

FILE: rtl/core/sshdfr_front.sv
// front end: banner and packet header parser, classifies each received word
// depends on sshdfr_pkg
`timescale 1ns / 1ps

module sshdfr_front #(
   parameter int PACKET_MAX = 4096,
   parameter int BANNER_CAP = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic                  operation,
   input  logic [7:0]            data_byte,
   output sshdfr_pkg::event_type result
);

   localparam int OFF_W = $clog2(PACKET_MAX);

   localparam logic [OFF_W-1:0] OFF_PADDING = OFF_W'(4);
   localparam logic [OFF_W-1:0] OFF_TYPE    = OFF_W'(5);
   localparam logic [31:0]      LENGTH_MAX  = 32'(PACKET_MAX - 4);
   localparam logic [7:0]       BANNER_KEEP = 8'(BANNER_CAP - 1);

   logic             banner_done_ff, banner_done_in;
   logic [7:0]       banner_count_ff, banner_count_in;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [31:0]      length_ff, length_in;
   logic             skip_ff, skip_in;
   logic [7:0]       type_ff, type_in;
   logic [OFF_W-1:0] plen_ff, plen_in;
   logic [OFF_W-1:0] payload_end_ff, payload_end_in;
   logic [OFF_W-1:0] last_off_ff, last_off_in;

   logic [32:0] pad_plus_one;
   logic [32:0] plen_wide;
   logic [31:0] plen_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         banner_done_ff  <= 1'b0;
         banner_count_ff <= '0;
         offset_ff       <= '0;
         length_ff       <= '0;
         skip_ff         <= 1'b0;
         type_ff         <= '0;
      end else if (take) begin
         banner_done_ff  <= banner_done_in;
         banner_count_ff <= banner_count_in;
         offset_ff       <= offset_in;
         length_ff       <= length_in;
         skip_ff         <= skip_in;
         type_ff         <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         plen_ff        <= plen_in;
         payload_end_ff <= payload_end_in;
         last_off_ff    <= last_off_in;
      end
   end

   always_comb begin
      pad_plus_one = 33'(data_byte) + 33'd1;
      plen_wide    = {1'b0, length_ff} - pad_plus_one;
      plen_ext     = 32'(plen_ff);
   end

   always_comb begin
      banner_done_in  = banner_done_ff;
      banner_count_in = banner_count_ff;
      offset_in       = offset_ff;
      length_in       = length_ff;
      skip_in         = skip_ff;
      type_in         = type_ff;
      plen_in         = plen_ff;
      payload_end_in  = payload_end_ff;
      last_off_in     = last_off_ff;
      result          = '0;
      result.kind     = sshdfr_pkg::KIND_NONE;

      if (operation) begin
         banner_done_in  = 1'b0;
         banner_count_in = '0;
         offset_in       = '0;
         length_in       = '0;
         skip_in         = 1'b0;
         type_in         = '0;
      end else if (!banner_done_ff) begin
         if (data_byte == sshdfr_pkg::CHAR_LF) begin
            banner_done_in = 1'b1;
            result.kind    = sshdfr_pkg::KIND_BANNER_END;
         end else if (data_byte != sshdfr_pkg::CHAR_CR &&
                      banner_count_ff < BANNER_KEEP) begin
            banner_count_in = banner_count_ff + 8'd1;
            result.kind     = sshdfr_pkg::KIND_BANNER_CHR;
            result.data     = data_byte;
         end
      end else if (offset_ff < OFF_PADDING) begin
         // big-endian length field
         length_in = {length_ff[23:0], data_byte};
         offset_in = offset_ff + OFF_W'(1);
      end else if (offset_ff == OFF_PADDING) begin
         if (length_ff < sshdfr_pkg::LENGTH_MIN || length_ff > LENGTH_MAX) begin
            result.kind = sshdfr_pkg::KIND_BAD_LENGTH;
            offset_in   = '0;
            length_in   = '0;
         end else begin
            // length fits the offset width here
            skip_in        = (pad_plus_one >= {1'b0, length_ff});
            plen_in        = plen_wide[OFF_W-1:0];
            payload_end_in = plen_wide[OFF_W-1:0] + OFF_W'(4);
            last_off_in    = length_ff[OFF_W-1:0] + OFF_W'(3);
            offset_in      = OFF_TYPE;
         end
      end else begin
         if (!skip_ff && offset_ff <= payload_end_ff) begin
            result.kind = sshdfr_pkg::KIND_PAYLOAD;
            result.data = data_byte;
            if (offset_ff == OFF_TYPE) begin
               type_in = data_byte;
            end
            result.payload_last = (offset_ff == payload_end_ff);
         end
         if (offset_ff >= last_off_ff) begin
            if (skip_ff) begin
               result.kind = sshdfr_pkg::KIND_BAD_PADDING;
            end else begin
               result.packet_end     = 1'b1;
               result.packet_type    = type_ff;
               result.payload_length = plen_ext[11:0];
            end
            offset_in = '0;
            length_in = '0;
            skip_in   = 1'b0;
         end else begin
            offset_in = offset_ff + OFF_W'(1);
         end
      end
   end

endmodule

FILE: rtl/core/sshdfr_queue.sv
// short queue of classified words between the front and the back
// depends on sshdfr_pkg
`timescale 1ns / 1ps

module sshdfr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sshdfr_pkg::event_type push_event,
   output logic                  full,
   input  logic                  pop,
   output sshdfr_pkg::event_type pop_event,
   output logic                  not_empty
);

   sshdfr_pkg::event_type entries_ff [sshdfr_pkg::QUEUE_DEPTH];

   logic [sshdfr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sshdfr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sshdfr_pkg::QCNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + sshdfr_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + sshdfr_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + sshdfr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - sshdfr_pkg::QCNT_W'(1);
      end
   end

   assign full      = (count_ff == sshdfr_pkg::QCNT_W'(sshdfr_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_event = entries_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/sshdfr_back.sv
// back end: keeps the error and packet counters and holds the result register
// depends on sshdfr_pkg
`timescale 1ns / 1ps

module sshdfr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  sshdfr_pkg::event_type q_event,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_kind,
   output logic [7:0]            rsp_data_out,
   output logic                  rsp_payload_last,
   output logic                  rsp_packet_end,
   output logic [7:0]            rsp_packet_type,
   output logic [11:0]           rsp_payload_length,
   output logic [31:0]           rsp_error_total,
   output logic [31:0]           rsp_packet_total
);

   logic                  valid_ff, valid_in;
   sshdfr_pkg::event_type word_ff;
   logic [31:0]           error_ff, error_in;
   logic [31:0]           packet_ff, packet_in;
   logic                  is_error;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         error_ff  <= '0;
         packet_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         error_ff  <= error_in;
         packet_ff <= packet_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         word_ff <= q_event;
      end
   end

   always_comb begin
      q_pop    = q_not_empty && (!valid_ff || !rsp_stall);
      is_error = (q_event.kind == sshdfr_pkg::KIND_BAD_LENGTH) ||
                 (q_event.kind == sshdfr_pkg::KIND_BAD_PADDING);
      valid_in = q_pop ? 1'b1 : (valid_ff && rsp_stall);
      error_in  = (q_pop && is_error) ? error_ff + 32'd1 : error_ff;
      packet_in = (q_pop && q_event.packet_end) ? packet_ff + 32'd1 : packet_ff;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = word_ff.kind;
   assign rsp_data_out       = word_ff.data;
   assign rsp_payload_last   = word_ff.payload_last;
   assign rsp_packet_end     = word_ff.packet_end;
   assign rsp_packet_type    = word_ff.packet_type;
   assign rsp_payload_length = word_ff.payload_length;
   // counters already include the word they ride with
   assign rsp_error_total    = error_ff;
   assign rsp_packet_total   = packet_ff;

endmodule

FILE: test/ssh_binary_packet_deframer_checker.sv
// operation codes for the deframer testbench, and the checker that predicts
// and compares every result word; depends on sshdfr_pkg from the rtl
`timescale 1ns / 1ps

package sshdfr_test_pkg;

   localparam logic OP_BYTE     = 1'b0;
   localparam logic OP_NEW_CONN = 1'b1;

endpackage

module ssh_binary_packet_deframer_checker
   import sshdfr_pkg::*, sshdfr_test_pkg::*;
#(
   parameter int PACKET_MAX = 4096,
   parameter int BANNER_CAP = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_data_out,
   input  logic        rsp_payload_last,
   input  logic        rsp_packet_end,
   input  logic [7:0]  rsp_packet_type,
   input  logic [11:0] rsp_payload_length,
   input  logic [31:0] rsp_error_total,
   input  logic [31:0] rsp_packet_total,
   output int          fail_count,
   output int          outstanding,
   output int          results_seen,
   output int          packets_seen,
   output int          errors_seen
);

   // four length bytes, then the padding length byte
   localparam int LEN_BYTES    = 4;
   localparam int HEADER_BYTES = 5;

   typedef struct packed {
      event_type   ev;
      logic [31:0] error_total;
      logic [31:0] packet_total;
   } result_word_type;

   logic        id_line_done;
   logic [7:0]  id_line_chars;
   logic [11:0] frame_pos;
   logic [31:0] frame_length;
   logic [7:0]  pad_length;
   logic        drop_frame;
   logic [7:0]  msg_type;
   logic [31:0] framing_errors;
   logic [31:0] frames_ok;

   result_word_type pending_results[$];
   result_word_type oldest;

   function automatic void clear_session();
      id_line_done  = 1'b0;
      id_line_chars = '0;
      frame_pos     = '0;
      frame_length  = '0;
      pad_length    = '0;
      drop_frame    = 1'b0;
      msg_type      = '0;
   endfunction

   function automatic result_word_type deframe_word(input logic op, input logic [7:0] b);
      result_word_type r;
      logic [31:0] last_pos;
      logic [31:0] body_len;
      r = '0;
      r.ev.kind = KIND_NONE;
      if (op == OP_NEW_CONN) begin
         clear_session();
      end else if (!id_line_done) begin
         if (b == CHAR_LF) begin
            id_line_done = 1'b1;
            r.ev.kind = KIND_BANNER_END;
         end else if (b != CHAR_CR && int'(id_line_chars) < BANNER_CAP - 1) begin
            id_line_chars = id_line_chars + 8'd1;
            r.ev.kind = KIND_BANNER_CHR;
            r.ev.data = b;
         end
      end else if (frame_pos < LEN_BYTES) begin
         frame_length = {frame_length[23:0], b};
         frame_pos = frame_pos + 12'd1;
      end else if (frame_pos == LEN_BYTES) begin
         if (frame_length < LENGTH_MIN || frame_length > 32'(PACKET_MAX - 4)) begin
            framing_errors = framing_errors + 32'd1;
            r.ev.kind = KIND_BAD_LENGTH;
            frame_pos = '0;
            frame_length = '0;
         end else begin
            pad_length = b;
            drop_frame = ({24'd0, b} + 32'd1 >= frame_length);
            frame_pos = 12'(HEADER_BYTES);
         end
      end else begin
         last_pos = frame_length + 32'd3;
         body_len = drop_frame ? 32'd0 : frame_length - {24'd0, pad_length} - 32'd1;
         if (!drop_frame && {20'd0, frame_pos} < HEADER_BYTES + body_len) begin
            r.ev.kind = KIND_PAYLOAD;
            r.ev.data = b;
            if (frame_pos == HEADER_BYTES)
               msg_type = b;
            if ({20'd0, frame_pos} == LEN_BYTES + body_len)
               r.ev.payload_last = 1'b1;
         end
         if ({20'd0, frame_pos} >= last_pos) begin
            if (drop_frame) begin
               framing_errors = framing_errors + 32'd1;
               r.ev.kind = KIND_BAD_PADDING;
            end else begin
               frames_ok = frames_ok + 32'd1;
               r.ev.packet_end = 1'b1;
               r.ev.packet_type = msg_type;
               r.ev.payload_length = body_len[11:0];
            end
            frame_pos = '0;
            frame_length = '0;
            pad_length = '0;
            drop_frame = 1'b0;
         end else begin
            frame_pos = frame_pos + 12'd1;
         end
      end
      r.error_total = framing_errors;
      r.packet_total = frames_ok;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_session();
         framing_errors = '0;
         frames_ok = '0;
         pending_results.delete();
         fail_count = 0;
         results_seen = 0;
      end else begin
         // push before pop so a same-cycle result would still find its word
         if (req_valid && !req_stall)
            pending_results.push_back(deframe_word(req_operation, req_data_byte));
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result word with no word outstanding");
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               check_field("kind", 32'(oldest.ev.kind), 32'(rsp_kind));
               check_field("data_out", 32'(oldest.ev.data), 32'(rsp_data_out));
               check_field("payload_last", 32'(oldest.ev.payload_last),
                           32'(rsp_payload_last));
               check_field("packet_end", 32'(oldest.ev.packet_end), 32'(rsp_packet_end));
               check_field("packet_type", 32'(oldest.ev.packet_type), 32'(rsp_packet_type));
               check_field("payload_length", 32'(oldest.ev.payload_length),
                           32'(rsp_payload_length));
               check_field("error_total", oldest.error_total, rsp_error_total);
               check_field("packet_total", oldest.packet_total, rsp_packet_total);
            end
         end
      end
      outstanding = pending_results.size();
      packets_seen = int'(frames_ok);
      errors_seen = int'(framing_errors);
   end

endmodule

FILE: test/ssh_binary_packet_deframer_tb.sv
// testbench top for the ssh binary packet deframer: clock, reset, word stimulus,
// random output stalls, watchdog and verdict; checking is done in
// ssh_binary_packet_deframer_checker, types come from sshdfr_pkg
`timescale 1ns / 1ps

module ssh_binary_packet_deframer_tb;
   import sshdfr_pkg::*;
   import sshdfr_test_pkg::*;

   localparam int PACKET_MAX      = 4096;
   localparam int BANNER_CAP      = 256;
   localparam int ITEM_TARGET     = 1300;
   localparam int IDLE_LIMIT      = 1000;
   localparam int HOLD_CYCLES     = 80;
   localparam int PRESSURE_LENGTH = 200;
   localparam int TAIL_CYCLES     = 20;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data_out;
   logic        rsp_payload_last;
   logic        rsp_packet_end;
   logic [7:0]  rsp_packet_type;
   logic [11:0] rsp_payload_length;
   logic [31:0] rsp_error_total;
   logic [31:0] rsp_packet_total;

   int fail_count;
   int outstanding;
   int results_seen;
   int packets_seen;
   int errors_seen;

   int words_sent = 0;
   int connections = 0;
   int quiet_cycles = 0;
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   ssh_binary_packet_deframer #(
      .PACKET_MAX(PACKET_MAX),
      .BANNER_CAP(BANNER_CAP)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_out       (rsp_data_out),
      .rsp_payload_last   (rsp_payload_last),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_error_total    (rsp_error_total),
      .rsp_packet_total   (rsp_packet_total)
   );

   ssh_binary_packet_deframer_checker #(
      .PACKET_MAX(PACKET_MAX),
      .BANNER_CAP(BANNER_CAP)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_out       (rsp_data_out),
      .rsp_payload_last   (rsp_payload_last),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_error_total    (rsp_error_total),
      .rsp_packet_total   (rsp_packet_total),
      .fail_count         (fail_count),
      .outstanding        (outstanding),
      .results_seen       (results_seen),
      .packets_seen       (packets_seen),
      .errors_seen        (errors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] banner_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == CHAR_LF);
      return c;
   endfunction

   task automatic send_word(input logic op, input logic [7:0] b);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(OP_BYTE, b);
   endtask

   task automatic send_banner(input int n_chars);
      for (int i = 0; i < n_chars; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_byte(CHAR_CR);
         send_byte(banner_char());
      end
      send_byte(CHAR_LF);
   endtask

   task automatic send_length(input logic [31:0] len);
      send_byte(len[31:24]);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   // len counts the padding length byte, payload and padding
   task automatic send_packet(input int len, input int pad);
      send_length(32'(len));
      send_byte(8'(pad));
      repeat (len - 1)
         send_byte(8'($urandom));
   endtask

   task automatic send_good_packet();
      int len;
      int max_pad;
      int r;
      len = ($urandom_range(0, 4) != 0) ? $urandom_range(6, 40) : $urandom_range(41, 300);
      max_pad = (len - 2 > 255) ? 255 : len - 2;
      r = $urandom_range(0, 5);
      if (r == 0)
         send_packet(len, 0);
      else if (r == 1)
         send_packet(len, max_pad);
      else
         send_packet(len, $urandom_range(0, max_pad));
   endtask

   task automatic send_bad_length();
      logic [31:0] len;
      case ($urandom_range(0, 2))
         0: len = $urandom_range(0, 5);
         1: len = $urandom_range(PACKET_MAX - 3, PACKET_MAX + 300);
         default: len = $urandom() | 32'h0000_1000;
      endcase
      send_length(len);
      send_byte(8'($urandom));
   endtask

   // receiver: random stall runs, plus one long hold-off on request
   initial begin : receiver
      int stall_len;
      int run_len;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall_len = calm ? 0 : pick_gap();
            run_len = $urandom_range(1, 12);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat (run_len) @(posedge clock);
         end
      end
   end

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int n_chars;
      int n_packets;
      int r;
      int len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: identification line with CR and top-value char
      send_byte(CHAR_CR);
      send_byte(8'h41);
      send_byte(8'hff);
      send_byte(CHAR_LF);
      // smallest packet, zero padding: last payload byte is the packet's last
      send_packet(6, 0);
      // length just under the minimum
      send_length(32'd5);
      send_byte(8'h00);
      // padding too long for the packet
      send_packet(6, 5);
      send_word(OP_NEW_CONN, 8'hff);

      // full banner, long output hold-off, largest legal length
      connections++;
      send_banner(BANNER_CAP + 4);
      hold_request = 1'b1;
      calm = 1'b1;
      send_packet(PRESSURE_LENGTH, 3);
      calm = 1'b0;
      // largest legal length passes the header check, then the packet is cut short
      send_length(32'(PACKET_MAX - 4));
      send_byte(8'h10);
      repeat (6)
         send_byte(8'($urandom));
      connections++;
      send_word(OP_NEW_CONN, 8'h00);
      send_byte(CHAR_LF);
      send_length(32'(PACKET_MAX - 3));
      send_byte(8'h00);
      send_packet(6, 4);

      while (words_sent < ITEM_TARGET) begin
         connections++;
         calm = ($urandom_range(0, 4) == 0);
         send_word(OP_NEW_CONN, 8'($urandom));
         n_chars = (connections % 6 == 0) ? $urandom_range(BANNER_CAP - 1, BANNER_CAP + 8)
                                          : $urandom_range(0, 24);
         send_banner(n_chars);
         n_packets = $urandom_range(1, 8);
         for (int k = 0; k < n_packets; k++) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
               send_good_packet();
            end else if (r < 82) begin
               len = $urandom_range(6, 256);
               send_packet(len, $urandom_range(len - 1, 255));
            end else if (r < 90) begin
               send_bad_length();
            end else if (r < 95) begin
               // stray words knock the framing off; start over afterwards
               repeat ($urandom_range(1, 3))
                  send_byte(8'($urandom));
               break;
            end else begin
               // packet cut short by a new connection
               len = $urandom_range(6, 40);
               send_length(32'(len));
               send_byte(8'($urandom_range(0, len - 2)));
               repeat ($urandom_range(0, len - 2))
                  send_byte(8'($urandom));
               break;
            end
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      wait (outstanding == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d words over %0d connections, %0d result words checked",
               words_sent, connections, results_seen);
      $display("%0d packets deframed, %0d framing errors counted", packets_seen, errors_seen);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
